@@ rtl/lstm_gate_matvec_assert.svh @@
// Assertion macros for the LSTM gate matrix-vector block.
// Depends on a clock clk_i and an active-low reset rst_ni in the including module.
`ifndef LSTM_GATE_MATVEC_ASSERT_SVH
`define LSTM_GATE_MATVEC_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define LGM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define LGM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/lgm_pkg.sv @@
// Shared types, constants and helpers for the LSTM gate matrix-vector block.
// No dependencies.
package lgm_pkg;

  localparam int HIDDEN_SIZE = 128;
  localparam int IDX_W       = $clog2(HIDDEN_SIZE);
  localparam int CNT_W       = $clog2(HIDDEN_SIZE + 1);
  localparam int FIELD_IDX_W = 7;
  localparam int DATA_W      = 16;
  localparam int CFG_W       = 8;
  localparam int FRAC_W      = 12;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ACC_W       = PROD_W + $clog2(HIDDEN_SIZE + 2) + 1;
  localparam int RW_ADDR_W   = 2 * IDX_W;
  localparam int RW_DEPTH    = HIDDEN_SIZE * HIDDEN_SIZE;
  localparam logic [CFG_W-1:0] ACTIVE_SIZE_RST = CFG_W'(128);

  typedef enum logic [1:0] {
    REQ_WR_RW   = 2'd0,
    REQ_WR_IW   = 2'd1,
    REQ_WR_HV   = 2'd2,
    REQ_COMPUTE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN1,
    S_DRAIN2,
    S_RESULT
  } state_e;

  typedef struct packed {
    req_e                    req_type;
    logic [FIELD_IDX_W-1:0]  row;
    logic [FIELD_IDX_W-1:0]  col;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] bias_value;
  } in_t;

  typedef struct packed {
    logic [FIELD_IDX_W-1:0]  out_row;
    logic signed [DATA_W-1:0] gate_value;
    logic                    saturated;
  } out_t;

  // store write command
  typedef struct packed {
    logic                     rw_we;
    logic                     iw_we;
    logic                     hv_we;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] bias;
  } wr_t;

  // store read address
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } rd_t;

  // registered store read data
  typedef struct packed {
    logic signed [DATA_W-1:0] rw;
    logic signed [DATA_W-1:0] hv;
    logic signed [DATA_W-1:0] iw;
    logic signed [DATA_W-1:0] bias;
  } rdata_t;

  // MAC control
  typedef struct packed {
    logic load;    // preload accumulator with bias
    logic mul_en;  // operands valid this cycle
  } mac_ctl_t;

  function automatic logic idx_ok(logic [FIELD_IDX_W-1:0] x);
    return 32'(x) < HIDDEN_SIZE;
  endfunction

  function automatic logic [IDX_W-1:0] to_idx(logic [FIELD_IDX_W-1:0] x);
    return IDX_W'(x);
  endfunction

endpackage

@@ rtl/lgm_store.sv @@
// Weight, bias and hidden vector storage with registered reads.
// Depends on lgm_pkg.
module lgm_store (
  input  logic            clk_i,
  input  lgm_pkg::wr_t    wr_i,
  input  lgm_pkg::rd_t    rd_i,
  output lgm_pkg::rdata_t rdata_o
);

  logic signed [lgm_pkg::DATA_W-1:0] rw_mem   [lgm_pkg::RW_DEPTH];
  logic signed [lgm_pkg::DATA_W-1:0] hv_mem   [lgm_pkg::HIDDEN_SIZE];
  logic signed [lgm_pkg::DATA_W-1:0] iw_mem   [lgm_pkg::HIDDEN_SIZE];
  logic signed [lgm_pkg::DATA_W-1:0] bias_mem [lgm_pkg::HIDDEN_SIZE];

  always_ff @(posedge clk_i) begin
    if (wr_i.rw_we) begin
      rw_mem[{wr_i.row, wr_i.col}] <= wr_i.value;
    end
    if (wr_i.hv_we) begin
      hv_mem[wr_i.col] <= wr_i.value;
    end
    if (wr_i.iw_we) begin
      iw_mem[wr_i.row]   <= wr_i.value;
      bias_mem[wr_i.row] <= wr_i.bias;
    end
    rdata_o.rw   <= rw_mem[{rd_i.row, rd_i.col}];
    rdata_o.hv   <= hv_mem[rd_i.col];
    rdata_o.iw   <= iw_mem[rd_i.row];
    rdata_o.bias <= bias_mem[rd_i.row];
  end

endmodule

@@ rtl/lgm_mac.sv @@
// Shared multiply-accumulate unit with Q8.24 to Q4.12 round and saturate.
// Depends on lgm_pkg.
module lgm_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lgm_pkg::mac_ctl_t                 ctl_i,
  input  logic signed [lgm_pkg::DATA_W-1:0] op_a_i,
  input  logic signed [lgm_pkg::DATA_W-1:0] op_b_i,
  input  logic signed [lgm_pkg::DATA_W-1:0] bias_i,
  output logic signed [lgm_pkg::DATA_W-1:0] gate_value_o,
  output logic                              saturated_o
);

  localparam int ACC_W  = lgm_pkg::ACC_W;
  localparam int FRAC_W = lgm_pkg::FRAC_W;
  localparam int DATA_W = lgm_pkg::DATA_W;
  localparam int HI_W   = ACC_W - FRAC_W - DATA_W + 1;

  logic                               pv_q;
  logic signed [lgm_pkg::PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]            acc_q, acc_d;
  logic signed [ACC_W-1:0]            rnd;
  logic [HI_W-1:0]                    hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctl_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
    acc_q  <= acc_d;
  end

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.load) begin
      acc_d = {{(ACC_W-DATA_W-FRAC_W){bias_i[DATA_W-1]}}, bias_i, {FRAC_W{1'b0}}};
    end else if (pv_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  // round half up, then clip when the upper bits are not a sign extension
  assign rnd = acc_q + ACC_W'(1 << (FRAC_W - 1));
  assign hi  = rnd[ACC_W-1:FRAC_W+DATA_W-1];

  always_comb begin
    saturated_o  = !((&hi) || (~|hi));
    gate_value_o = rnd[FRAC_W+DATA_W-1:FRAC_W];
    if (saturated_o) begin
      gate_value_o = rnd[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

@@ rtl/lstm_gate_matvec.sv @@
// LSTM gate pre-activation row: sequencer, config register and output register.
// Depends on lgm_pkg, lgm_store, lgm_mac and lstm_gate_matvec_assert.svh.
//
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i): one request per transfer.
//     Types 0..2 write a recurrent weight, an input weight plus bias, or a
//     hidden element and give no result.
//     Type 3 computes row r: x*iw[r] + sum_{k<n} h[k]*W[r][k] + b[r], with
//     n = min(active_size, HIDDEN_SIZE). Rows at or beyond n are dropped.
//   out channel (out_valid_o/out_ready_i/out_data_o): one result per kept
//     compute request, rounded to nearest (ties up) and saturated to Q4.12.
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i): writes active_size;
//     always ready, to be used only while the block is idle.
// Timing: a compute runs through the single shared multiplier, from transfer
//   to ready again: S_RUN streams the input term and the hidden/weight pairs,
//   then the pipeline drains in S_DRAIN1 and S_DRAIN2, and S_RESULT loads the
//   result into the output register. Writes leave the block idle.
// Stall: a result waits in the output register; the next request is taken
//   meanwhile and a new compute holds in its result cycle until it drains.
// Reset: active_size returns to 128, control clears; the stores keep no reset.
`include "lstm_gate_matvec_assert.svh"

module lstm_gate_matvec (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lgm_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lgm_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lgm_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int IDX_W = lgm_pkg::IDX_W;
  localparam int CNT_W = lgm_pkg::CNT_W;

  lgm_pkg::state_e                          state_q, state_d;
  logic [IDX_W-1:0]                         k_q, k_d;
  logic [lgm_pkg::FIELD_IDX_W-1:0]          row_q, row_d;
  logic signed [lgm_pkg::DATA_W-1:0]        val_q, val_d;
  logic                                     rdv_q;
  logic [lgm_pkg::CFG_W-1:0]                active_size_q;
  logic [CNT_W-1:0]                         n_w;
  logic                                     in_fire;
  logic                                     row_kept;
  logic                                     first;
  logic                                     out_load;
  logic                                     out_valid_q;
  lgm_pkg::out_t                            out_q;

  lgm_pkg::wr_t                             wr;
  lgm_pkg::rd_t                             rd;
  lgm_pkg::rdata_t                          rdata;
  lgm_pkg::mac_ctl_t                        mac_ctl;
  logic signed [lgm_pkg::DATA_W-1:0]        op_a, op_b;
  logic signed [lgm_pkg::DATA_W-1:0]        gate_value;
  logic                                     saturated;

  // config register, to be written only while idle; the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_size_q <= lgm_pkg::ACTIVE_SIZE_RST;
    end else if (cfg_valid_i) begin
      active_size_q <= cfg_data_i;
    end
  end

  // effective size n = min(active_size, HIDDEN_SIZE)
  assign n_w = (32'(active_size_q) < lgm_pkg::HIDDEN_SIZE) ? CNT_W'(active_size_q)
                                                          : CNT_W'(lgm_pkg::HIDDEN_SIZE);

  assign in_ready_o = (state_q == lgm_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign row_kept   = 32'(in_data_i.row) < 32'(n_w);

  // first streaming cycle carries the input term and the bias preload
  assign first = (state_q == lgm_pkg::S_RUN) && (k_q == '0);

  // store addresses: row follows the request while idle so iw/bias are
  // ready in the first streaming cycle
  assign rd.row = (state_q == lgm_pkg::S_IDLE) ? lgm_pkg::to_idx(in_data_i.row)
                                               : lgm_pkg::to_idx(row_q);
  assign rd.col = k_q;

  assign op_a = first ? val_q    : rdata.hv;
  assign op_b = first ? rdata.iw : rdata.rw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lgm_pkg::S_IDLE;
      k_q     <= '0;
      rdv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      rdv_q   <= (state_q == lgm_pkg::S_RUN);
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    val_q <= val_d;
  end

  always_comb begin
    state_d        = state_q;
    k_d            = k_q;
    row_d          = row_q;
    val_d          = val_q;
    out_load       = 1'b0;
    mac_ctl.load   = first;
    mac_ctl.mul_en = first || rdv_q;
    wr.rw_we       = 1'b0;
    wr.iw_we       = 1'b0;
    wr.hv_we       = 1'b0;
    wr.row         = lgm_pkg::to_idx(in_data_i.row);
    wr.col         = lgm_pkg::to_idx(in_data_i.col);
    wr.value       = in_data_i.value;
    wr.bias        = in_data_i.bias_value;
    unique case (state_q)
      lgm_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_data_i.req_type)
            lgm_pkg::REQ_WR_RW: begin
              wr.rw_we = lgm_pkg::idx_ok(in_data_i.row) && lgm_pkg::idx_ok(in_data_i.col);
            end
            lgm_pkg::REQ_WR_IW: begin
              wr.iw_we = lgm_pkg::idx_ok(in_data_i.row);
            end
            lgm_pkg::REQ_WR_HV: begin
              wr.hv_we = lgm_pkg::idx_ok(in_data_i.col);
            end
            lgm_pkg::REQ_COMPUTE: begin
              if (row_kept) begin
                state_d = lgm_pkg::S_RUN;
                k_d     = '0;
                row_d   = in_data_i.row;
                val_d   = in_data_i.value;
              end
            end
            default: ;
          endcase
        end
      end
      lgm_pkg::S_RUN: begin
        k_d = k_q + 1'b1;
        if (32'(k_q) == 32'(n_w) - 1) begin
          k_d     = '0;
          state_d = lgm_pkg::S_DRAIN1;
        end
      end
      lgm_pkg::S_DRAIN1: state_d = lgm_pkg::S_DRAIN2;
      lgm_pkg::S_DRAIN2: state_d = lgm_pkg::S_RESULT;
      lgm_pkg::S_RESULT: begin
        out_load = !out_valid_q || out_ready_i;
        if (out_load) begin
          state_d = lgm_pkg::S_IDLE;
        end
      end
      default: state_d = lgm_pkg::S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.out_row    <= row_q;
      out_q.gate_value <= gate_value;
      out_q.saturated  <= saturated;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  lgm_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  lgm_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (mac_ctl),
    .op_a_i       (op_a),
    .op_b_i       (op_b),
    .bias_i       (rdata.bias),
    .gate_value_o (gate_value),
    .saturated_o  (saturated)
  );

  // assertions
  `LGM_ASSERT(a_k_in_range, (state_q == lgm_pkg::S_RUN) |-> (32'(k_q) < 32'(n_w)), "k past n")
  `LGM_ASSERT(a_start_run, (in_fire && in_data_i.req_type == lgm_pkg::REQ_COMPUTE && row_kept) |=> (state_q == lgm_pkg::S_RUN && k_q == '0), "compute did not start")
  `LGM_ASSERT(a_drop_row, (in_fire && !(in_data_i.req_type == lgm_pkg::REQ_COMPUTE && row_kept)) |=> (state_q == lgm_pkg::S_IDLE), "dropped request left idle")
  `LGM_ASSERT(a_dot_window, rdv_q |-> (state_q == lgm_pkg::S_RUN || state_q == lgm_pkg::S_DRAIN1), "stray read data")
  `LGM_ASSERT(a_result_wait, (state_q == lgm_pkg::S_RESULT && out_valid_o && !out_ready_i) |=> (state_q == lgm_pkg::S_RESULT && out_valid_o), "result overwrote pending output")

endmodule

@@ bench/lstm_gate_matvec_tb.sv @@
// Self-checking testbench for lstm_gate_matvec: Q4.12 gate row sums.
// Depends on lgm_pkg and the lstm_gate_matvec RTL; reads no files.
// Directed rounding, saturation and size corner cases, then random traffic with valid/ready gaps.
module lstm_gate_matvec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Pause before config writes, longer than a compute on the full hidden size.
  localparam int DRAIN_CYCLES = lgm_pkg::HIDDEN_SIZE + 12;
  // Long output hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES  = 300;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 90;
  localparam int IDLE_PCT     = 7;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  lgm_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b1;
  lgm_pkg::out_t out_data_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [lgm_pkg::CFG_W-1:0] cfg_data_i = '0;

  // Shadow copy of the block's stores and size register.
  logic signed [lgm_pkg::DATA_W-1:0] w_rec [lgm_pkg::RW_DEPTH];
  logic signed [lgm_pkg::DATA_W-1:0] w_in  [lgm_pkg::HIDDEN_SIZE];
  logic signed [lgm_pkg::DATA_W-1:0] b_row [lgm_pkg::HIDDEN_SIZE];
  logic signed [lgm_pkg::DATA_W-1:0] h_vec [lgm_pkg::HIDDEN_SIZE];
  // Written flags: a compute is only issued once every entry it reads is set.
  bit rec_set [lgm_pkg::RW_DEPTH];
  bit in_set  [lgm_pkg::HIDDEN_SIZE];
  bit hid_set [lgm_pkg::HIDDEN_SIZE];
  int cur_size = int'(lgm_pkg::ACTIVE_SIZE_RST);

  lgm_pkg::out_t pending_gates [$];
  int   sent_items  = 0;
  int   gate_checks = 0;
  int   mismatches  = 0;
  bit   no_idle     = 1'b0;
  bit   hold_req    = 1'b0;

  lstm_gate_matvec i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int active_n();
    return (cur_size < lgm_pkg::HIDDEN_SIZE) ? cur_size : lgm_pkg::HIDDEN_SIZE;
  endfunction

  // True once iw/bias, the first n weights of the row and the first n hidden
  // elements have all been written.
  function automatic bit row_ready(input int r);
    int n;
    n = active_n();
    if (!in_set[r]) return 1'b0;
    for (int k = 0; k < n; k++) begin
      if (!hid_set[k] || !rec_set[r*lgm_pkg::HIDDEN_SIZE + k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Apply one accepted request to the shadow stores; a kept compute queues its
  // gate sum. Exact sum is Q8.24, rounded half up to Q4.12, then clipped.
  function automatic void model_request(input lgm_pkg::in_t rq);
    int            n;
    int            r;
    int            c;
    longint        acc;
    longint        q;
    lgm_pkg::out_t res;
    n = active_n();
    r = int'(rq.row);
    c = int'(rq.col);
    case (rq.req_type)
      lgm_pkg::REQ_WR_RW: begin
        w_rec[r*lgm_pkg::HIDDEN_SIZE + c]   = rq.value;
        rec_set[r*lgm_pkg::HIDDEN_SIZE + c] = 1'b1;
      end
      lgm_pkg::REQ_WR_IW: begin
        w_in[r]   = rq.value;
        b_row[r]  = rq.bias_value;
        in_set[r] = 1'b1;
      end
      lgm_pkg::REQ_WR_HV: begin
        h_vec[c]   = rq.value;
        hid_set[c] = 1'b1;
      end
      default: begin
        if (r < n) begin
          acc = longint'($signed(rq.value)) * longint'(w_in[r]);
          for (int k = 0; k < n; k++)
            acc += longint'(h_vec[k]) * longint'(w_rec[r*lgm_pkg::HIDDEN_SIZE + k]);
          acc += longint'(b_row[r]) * 4096;
          q = (acc + 2048) >>> lgm_pkg::FRAC_W;
          res.saturated = 1'b0;
          if (q > 32767) begin
            q = 32767;
            res.saturated = 1'b1;
          end else if (q < -32768) begin
            q = -32768;
            res.saturated = 1'b1;
          end
          res.out_row    = rq.row;
          res.gate_value = q[lgm_pkg::DATA_W-1:0];
          pending_gates.push_back(res);
        end
      end
    endcase
  endfunction

  function automatic lgm_pkg::in_t mk(input lgm_pkg::req_e t, input int row, input int col,
                                      input int value, input int bias);
    lgm_pkg::in_t rq;
    rq.req_type   = t;
    rq.row        = lgm_pkg::FIELD_IDX_W'(row);
    rq.col        = lgm_pkg::FIELD_IDX_W'(col);
    rq.value      = lgm_pkg::DATA_W'(value);
    rq.bias_value = lgm_pkg::DATA_W'(bias);
    return rq;
  endfunction

  // Mostly small Q4.12 values so sums stay in range; some full-range and extremes.
  function automatic int rand_q();
    case ($urandom_range(9))
      0:       return int'($urandom_range(65535));
      1:       return ($urandom_range(1) != 0) ? 32767 : -32768;
      default: return int'($urandom_range(8191)) - 4096;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR: %s", msg);
  endtask

  // One input transfer. Valid stays high across back-to-back items; a random
  // gap lowers it first.
  task automatic send_req(input lgm_pkg::in_t rq);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    do @(posedge clk_i); while (!in_ready_o);
    model_request(rq);
    sent_items++;
  endtask

  // Drop valid, let every queued result arrive, then pause before the next config write.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_gates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_size(input int v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lgm_pkg::CFG_W'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_size = v;
  endtask

  // Hidden elements in use: write any unset ones, refresh some at random.
  task automatic fill_hidden();
    for (int k = 0; k < active_n(); k++) begin
      if (!hid_set[k] || $urandom_range(3) == 0)
        send_req(mk(lgm_pkg::REQ_WR_HV, $urandom_range(127), k, rand_q(), rand_q()));
    end
  endtask

  task automatic load_row(input int r, input int cols);
    send_req(mk(lgm_pkg::REQ_WR_IW, r, $urandom_range(127), rand_q(), rand_q()));
    for (int k = 0; k < cols; k++)
      send_req(mk(lgm_pkg::REQ_WR_RW, r, k, rand_q(), rand_q()));
  endtask

  task automatic compute_row(input int r, input int x);
    send_req(mk(lgm_pkg::REQ_COMPUTE, r, $urandom_range(127), x, rand_q()));
  endtask

  // Size 1: rounding ties both ways, exact range ends, both saturation sides,
  // dropped rows and writes at the top indexes.
  task automatic test_rounding_and_saturation();
    set_size(1);
    send_req(mk(lgm_pkg::REQ_WR_HV, 0, 0, 1, 0));
    send_req(mk(lgm_pkg::REQ_WR_IW, 0, 0, 0, 0));
    send_req(mk(lgm_pkg::REQ_WR_RW, 0, 0, 2048, 0));
    compute_row(0, 0);                        // +0.5 lsb tie rounds up to 1
    send_req(mk(lgm_pkg::REQ_WR_RW, 0, 0, -2048, 0));
    compute_row(0, 0);                        // -0.5 lsb tie rounds up to 0
    send_req(mk(lgm_pkg::REQ_WR_RW, 0, 0, 0, 0));
    send_req(mk(lgm_pkg::REQ_WR_IW, 0, 0, 0, -32768));
    compute_row(0, 12345);                    // exactly the minimum, no clip
    send_req(mk(lgm_pkg::REQ_WR_IW, 0, 0, 0, 32767));
    compute_row(0, -1);                       // exactly the maximum, no clip
    send_req(mk(lgm_pkg::REQ_WR_IW, 0, 0, 32767, 32767));
    compute_row(0, 32767);                    // clips high
    send_req(mk(lgm_pkg::REQ_WR_IW, 0, 0, -32768, -32768));
    compute_row(0, 32767);                    // clips low
    compute_row(0, -32768);                   // product of two minimums clips high
    compute_row(1, 100);                      // row at the active size: dropped
    compute_row(127, 100);                    // top row: dropped
    send_req(mk(lgm_pkg::REQ_WR_RW, 127, 127, -32768, 32767));
    send_req(mk(lgm_pkg::REQ_WR_HV, 127, 127, 32767, -32768));
    send_req(mk(lgm_pkg::REQ_WR_IW, 127, 127, 32767, -32768));
    wait_idle();
  endtask

  // Full length dot product on the top row.
  task automatic test_full_size();
    set_size(128);
    fill_hidden();
    load_row(127, 128);
    compute_row(127, 32767);
    compute_row(127, -32768);
    compute_row(127, rand_q());
    wait_idle();
  endtask

  // Output held off for a long stretch while computes keep coming, so the
  // result register fills and the input stalls.
  task automatic test_output_stall();
    set_size(8);
    fill_hidden();
    for (int r = 0; r < 8; r++) load_row(r, 8);
    hold_req = 1'b1;
    repeat (16) compute_row($urandom_range(7), rand_q());
    wait_idle();
  endtask

  // Mostly load-then-compute sequences with random content; the rest are
  // computes of loaded or out-of-range rows, half-finished loads and raw noise.
  task automatic random_sequence();
    int           n;
    int           r;
    int           r2;
    int           pick;
    lgm_pkg::in_t rq;
    n    = active_n();
    pick = $urandom_range(99);
    r    = $urandom_range(n - 1);
    if (pick < 60) begin
      load_row(r, n);
      repeat ($urandom_range(1, 3)) compute_row(r, rand_q());
    end else if (pick < 75) begin
      r2 = (pick < 68) ? r : int'($urandom_range(127));
      if (r2 >= n || row_ready(r2)) compute_row(r2, rand_q());
    end else if (pick < 85) begin
      load_row(r, $urandom_range(n - 1));
    end else begin
      rq = mk(lgm_pkg::req_e'($urandom_range(3)), $urandom_range(127), $urandom_range(127),
              $urandom_range(65535), $urandom_range(65535));
      // never compute a row whose operands are not all written
      if (rq.req_type == lgm_pkg::REQ_COMPUTE && int'(rq.row) < n &&
          !row_ready(int'(rq.row)))
        rq.req_type = lgm_pkg::REQ_WR_HV;
      send_req(rq);
    end
  endtask

  task automatic test_random_traffic();
    int sizes [6];
    int start;
    sizes = '{3, 1, 16, 127, 40, 7};
    for (int p = 0; p < 6; p++) begin
      set_size(sizes[p]);
      no_idle = (p == 2);                     // one phase with no gaps at all
      fill_hidden();
      start = sent_items;
      while (sent_items - start < PHASE_ITEMS) random_sequence();
      wait_idle();
      no_idle = 1'b0;
    end
  endtask

  // Result checker and output-ready driver. Also owns the long hold-off.
  initial begin : result_check
    int            hold_left;
    lgm_pkg::out_t want;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        gate_checks++;
        if (pending_gates.size() == 0) begin
          report_mismatch($sformatf("result for row %0d with none pending",
                                    out_data_o.out_row));
        end else begin
          want = pending_gates.pop_front();
          if (out_data_o.out_row !== want.out_row)
            report_mismatch($sformatf("out_row %0d, expected %0d",
                                      out_data_o.out_row, want.out_row));
          if (out_data_o.gate_value !== want.gate_value)
            report_mismatch($sformatf("row %0d gate_value %0d, expected %0d", want.out_row,
                                      out_data_o.gate_value, want.gate_value));
          if (out_data_o.saturated !== want.saturated)
            report_mismatch($sformatf("row %0d saturated %0b, expected %0b", want.out_row,
                                      out_data_o.saturated, want.saturated));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Hang detector: counts cycles in which no channel completes a transfer.
  initial begin : stall_watch
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_rounding_and_saturation();
    test_full_size();
    test_output_stall();
    test_random_traffic();
    if (pending_gates.size() != 0)
      report_mismatch($sformatf("%0d gate results never arrived", pending_gates.size()));
    $display("Covered %0d requests over active sizes 1 to 128, %0d gate results compared,",
             sent_items, gate_checks);
    $display("with random gaps on both sides and one %0d-cycle output hold-off.", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lgm_pkg.sv
rtl/lgm_store.sv
rtl/lgm_mac.sv
rtl/lstm_gate_matvec.sv
bench/lstm_gate_matvec_tb.sv
